@@ rtl/chc_pkg.sv @@
// shared types, constants and arctangent table for the compass heading pipeline
`default_nettype none
package chc_pkg;

  localparam int ANG_W = 24;
  localparam int TRIG_W = 20;
  localparam int VEC_W = 36;
  localparam int MAX_STEPS = 24;

  localparam logic signed [TRIG_W-1:0] TRIG_GAIN = 20'sd39797;
  localparam logic signed [ANG_W-1:0] HALF_TURN = 24'sd4608000;

  localparam logic [2:0] REG_OFFSET_X = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y = 3'd1;
  localparam logic [2:0] REG_OFFSET_Z = 3'd2;
  localparam logic [2:0] REG_SCALE_Y = 3'd3;
  localparam logic [2:0] REG_SCALE_Z = 3'd4;
  localparam logic [2:0] REG_BYPASS = 3'd5;
  localparam logic [2:0] REG_DECLINATION = 3'd6;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } axes_t;

  typedef struct packed {
    logic neg;
    logic signed [ANG_W-1:0] z;
  } ang_t;

  typedef struct packed {
    axes_t ax;
    logic signed [17:0] hx;
    logic signed [17:0] hy;
    logic spec;
    logic signed [15:0] spec_val;
  } post_t;

  function automatic logic signed [ANG_W-1:0] atan_val(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0: v = 24'sd1152000;
      1: v = 24'sd680065;
      2: v = 24'sd359328;
      3: v = 24'sd182400;
      4: v = 24'sd91554;
      5: v = 24'sd45822;
      6: v = 24'sd22916;
      7: v = 24'sd11459;
      8: v = 24'sd5730;
      9: v = 24'sd2865;
      10: v = 24'sd1432;
      11: v = 24'sd716;
      12: v = 24'sd358;
      13: v = 24'sd179;
      14: v = 24'sd90;
      15: v = 24'sd45;
      16: v = 24'sd22;
      17: v = 24'sd11;
      18: v = 24'sd6;
      19: v = 24'sd3;
      20: v = 24'sd1;
      21: v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

  // reduce to (-180,180], then fold into [-90,90] and scale to 1/256 centidegree
  function automatic ang_t fold_angle(input logic signed [16:0] a);
    logic signed [16:0] r;
    logic signed [ANG_W-1:0] w;
    ang_t o;
    r = a;
    if (r > 17'sd18000) r = r - 17'sd36000;
    else if (r <= -17'sd18000) r = r + 17'sd36000;
    o.neg = 1'b0;
    if (r > 17'sd9000) begin
      r = r - 17'sd18000;
      o.neg = 1'b1;
    end else if (r < -17'sd9000) begin
      r = r + 17'sd18000;
      o.neg = 1'b1;
    end
    w = ANG_W'(r);
    o.z = w <<< 8;
    return o;
  endfunction

endpackage
`default_nettype wire

@@ rtl/chc_rot_stage.sv @@
// one rotation iteration of the sine and cosine cordic
`default_nettype none
module chc_rot_stage #(
  parameter int SHIFT = 0
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [chc_pkg::TRIG_W-1:0] x_in,
  input  wire logic signed [chc_pkg::TRIG_W-1:0] y_in,
  input  wire logic signed [chc_pkg::ANG_W-1:0] z_in,
  output logic signed [chc_pkg::TRIG_W-1:0] x_out,
  output logic signed [chc_pkg::TRIG_W-1:0] y_out,
  output logic signed [chc_pkg::ANG_W-1:0] z_out
);

  localparam logic signed [chc_pkg::ANG_W-1:0] ATAN = chc_pkg::atan_val(SHIFT);

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_in >= 0) begin
        x_out <= x_in - (y_in >>> SHIFT);
        y_out <= y_in + (x_in >>> SHIFT);
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + (y_in >>> SHIFT);
        y_out <= y_in - (x_in >>> SHIFT);
        z_out <= z_in + ATAN;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/chc_vec_stage.sv @@
// one vectoring iteration of the arctangent cordic
`default_nettype none
module chc_vec_stage #(
  parameter int SHIFT = 0
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [chc_pkg::VEC_W-1:0] x_in,
  input  wire logic signed [chc_pkg::VEC_W-1:0] y_in,
  input  wire logic signed [chc_pkg::ANG_W-1:0] z_in,
  output logic signed [chc_pkg::VEC_W-1:0] x_out,
  output logic signed [chc_pkg::VEC_W-1:0] y_out,
  output logic signed [chc_pkg::ANG_W-1:0] z_out
);

  localparam logic signed [chc_pkg::ANG_W-1:0] ATAN = chc_pkg::atan_val(SHIFT);

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in > 0) begin
        x_out <= x_in + (y_in >>> SHIFT);
        y_out <= y_in - (x_in >>> SHIFT);
        z_out <= z_in + ATAN;
      end else begin
        x_out <= x_in - (y_in >>> SHIFT);
        y_out <= y_in + (x_in >>> SHIFT);
        z_out <= z_in - ATAN;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/compass_heading_calc_top.sv @@
// top level of the tilt compensated compass heading pipeline
// Takes one sample word per cycle unless stalled and returns one result word per
// sample, in order. The stages (cordic steps capped at 24) are three calibration stages,
// the sine/cosine cordic (one stage per iteration), three tilt product stages, one
// arctangent setup stage, the arctangent cordic (one stage per iteration) and the output
// register. All stages advance together; a stall on the output holds the whole
// pipeline, and in_stall follows out_valid and out_stall.
`default_nettype none
module compass_heading_calc_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [15:0] raw_first_word,
  input  wire logic signed [15:0] raw_second_word,
  input  wire logic signed [15:0] raw_third_word,
  input  wire logic signed [15:0] roll_angle,
  input  wire logic signed [15:0] pitch_angle,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] heading,
  output logic signed [15:0] corrected_x,
  output logic signed [15:0] corrected_y,
  output logic signed [15:0] corrected_z,
  output logic signed [17:0] horizontal_x,
  output logic signed [17:0] horizontal_y,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int NSTEPS = (CORDIC_STEPS > chc_pkg::MAX_STEPS) ? chc_pkg::MAX_STEPS
                                                                : CORDIC_STEPS;
  localparam int TW = chc_pkg::TRIG_W;
  localparam int VW = chc_pkg::VEC_W;
  localparam int AW = chc_pkg::ANG_W;

  // configuration
  logic signed [15:0] offset_x, offset_y, offset_z, declination;
  logic [15:0] scale_y, scale_z;
  logic calibration_bypass;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      scale_y <= 16'd4096;
      scale_z <= 16'd4096;
      calibration_bypass <= 1'b0;
      declination <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        chc_pkg::REG_OFFSET_X: offset_x <= cfg_data;
        chc_pkg::REG_OFFSET_Y: offset_y <= cfg_data;
        chc_pkg::REG_OFFSET_Z: offset_z <= cfg_data;
        chc_pkg::REG_SCALE_Y: scale_y <= cfg_data;
        chc_pkg::REG_SCALE_Z: scale_z <= cfg_data;
        chc_pkg::REG_BYPASS: calibration_bypass <= cfg_data[0];
        chc_pkg::REG_DECLINATION: declination <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: inversion, offsets unless bypassed, angle reduction
  logic s1_v;
  chc_pkg::axes_t s1_ax;
  logic s1_byp;
  chc_pkg::ang_t s1_roll, s1_pitch;
  logic signed [15:0] ny, nx;
  logic signed [16:0] neg_pitch;

  assign ny = 16'(-raw_first_word);
  assign nx = 16'(-raw_third_word);
  assign neg_pitch = -17'(pitch_angle);

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_byp <= calibration_bypass;
      if (calibration_bypass) begin
        s1_ax.x <= nx;
        s1_ax.y <= ny;
        s1_ax.z <= raw_second_word;
      end else begin
        s1_ax.x <= nx + offset_x;
        s1_ax.y <= ny + offset_y;
        s1_ax.z <= raw_second_word + offset_z;
      end
      s1_roll <= chc_pkg::fold_angle(17'(roll_angle));
      s1_pitch <= chc_pkg::fold_angle(neg_pitch);
    end
  end

  // stage 2: gain products
  logic s2_v, s2_byp;
  chc_pkg::axes_t s2_ax;
  chc_pkg::ang_t s2_roll, s2_pitch;
  logic signed [32:0] s2_py, s2_pz;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_byp <= s1_byp;
      s2_ax <= s1_ax;
      s2_roll <= s1_roll;
      s2_pitch <= s1_pitch;
      s2_py <= 33'(s1_ax.y) * 33'($signed({1'b0, scale_y}));
      s2_pz <= 33'(s1_ax.z) * 33'($signed({1'b0, scale_z}));
    end
  end

  // stage 3: truncate toward zero and saturate
  logic s3_v;
  chc_pkg::axes_t s3_ax;
  chc_pkg::ang_t s3_roll, s3_pitch;
  logic signed [32:0] qy, qz;
  logic signed [15:0] sy, sz;

  assign qy = (s2_py + (s2_py[32] ? 33'sd4095 : 33'sd0)) >>> 12;
  assign qz = (s2_pz + (s2_pz[32] ? 33'sd4095 : 33'sd0)) >>> 12;

  always_comb begin
    if (qy > 33'sd32767) sy = 16'sh7fff;
    else if (qy < -33'sd32768) sy = 16'sh8000;
    else sy = 16'(qy);
    if (qz > 33'sd32767) sz = 16'sh7fff;
    else if (qz < -33'sd32768) sz = 16'sh8000;
    else sz = 16'(qz);
  end

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ax.x <= s2_ax.x;
      s3_ax.y <= s2_byp ? s2_ax.y : sy;
      s3_ax.z <= s2_byp ? s2_ax.z : sz;
      s3_roll <= s2_roll;
      s3_pitch <= s2_pitch;
    end
  end

  // sine and cosine cordic, roll and pitch side by side
  logic signed [TW-1:0] rx [0:NSTEPS];
  logic signed [TW-1:0] ry [0:NSTEPS];
  logic signed [AW-1:0] rz [0:NSTEPS];
  logic signed [TW-1:0] px [0:NSTEPS];
  logic signed [TW-1:0] py [0:NSTEPS];
  logic signed [AW-1:0] pz [0:NSTEPS];
  logic tv [0:NSTEPS];
  logic tneg_r [0:NSTEPS];
  logic tneg_p [0:NSTEPS];
  chc_pkg::axes_t tax [0:NSTEPS];

  assign rx[0] = chc_pkg::TRIG_GAIN;
  assign ry[0] = '0;
  assign rz[0] = s3_roll.z;
  assign px[0] = chc_pkg::TRIG_GAIN;
  assign py[0] = '0;
  assign pz[0] = s3_pitch.z;
  assign tv[0] = s3_v;
  assign tneg_r[0] = s3_roll.neg;
  assign tneg_p[0] = s3_pitch.neg;
  assign tax[0] = s3_ax;

  for (genvar k = 0; k < NSTEPS; k++) begin : g_trig
    chc_rot_stage #(.SHIFT(k)) u_roll (
      .clk(clk), .en(adv),
      .x_in(rx[k]), .y_in(ry[k]), .z_in(rz[k]),
      .x_out(rx[k+1]), .y_out(ry[k+1]), .z_out(rz[k+1])
    );
    chc_rot_stage #(.SHIFT(k)) u_pitch (
      .clk(clk), .en(adv),
      .x_in(px[k]), .y_in(py[k]), .z_in(pz[k]),
      .x_out(px[k+1]), .y_out(py[k+1]), .z_out(pz[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) tv[k+1] <= 1'b0;
      else if (adv) tv[k+1] <= tv[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        tneg_r[k+1] <= tneg_r[k];
        tneg_p[k+1] <= tneg_p[k];
        tax[k+1] <= tax[k];
      end
    end
  end

  // tilt stage a: sign fix and first products
  logic signed [TW-1:0] cp, sp, cr, sr;
  assign cr = tneg_r[NSTEPS] ? -rx[NSTEPS] : rx[NSTEPS];
  assign sr = tneg_r[NSTEPS] ? -ry[NSTEPS] : ry[NSTEPS];
  assign cp = tneg_p[NSTEPS] ? -px[NSTEPS] : px[NSTEPS];
  assign sp = tneg_p[NSTEPS] ? -py[NSTEPS] : py[NSTEPS];

  logic ta_v;
  chc_pkg::axes_t ta_ax;
  logic signed [2*TW-1:0] ta_srsp, ta_crsp;
  logic signed [TW+15:0] ta_xcp, ta_ycr, ta_zsr;

  always_ff @(posedge clk) begin
    if (rst) ta_v <= 1'b0;
    else if (adv) ta_v <= tv[NSTEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ta_ax <= tax[NSTEPS];
      ta_srsp <= (2*TW)'(sr) * (2*TW)'(sp);
      ta_crsp <= (2*TW)'(cr) * (2*TW)'(sp);
      ta_xcp <= (TW+16)'(tax[NSTEPS].x) * (TW+16)'(cp);
      ta_ycr <= (TW+16)'(tax[NSTEPS].y) * (TW+16)'(cr);
      ta_zsr <= (TW+16)'(tax[NSTEPS].z) * (TW+16)'(sr);
    end
  end

  // tilt stage b: second products and horizontal y
  logic tb_v;
  chc_pkg::axes_t tb_ax;
  logic signed [2*TW+15:0] tb_my, tb_mz;
  logic signed [TW+15:0] tb_xcp;
  logic signed [17:0] tb_hy;
  logic signed [TW+16:0] hy_sum, hy_sh;
  logic signed [17:0] hy_sat;

  assign hy_sum = (TW+17)'(ta_ycr) + (TW+17)'(ta_zsr) + (TW+17)'(32768);
  assign hy_sh = hy_sum >>> 16;

  always_comb begin
    if (hy_sh > (TW+17)'(131071)) hy_sat = 18'sh1ffff;
    else if (hy_sh < -(TW+17)'(131072)) hy_sat = 18'sh20000;
    else hy_sat = 18'(hy_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) tb_v <= 1'b0;
    else if (adv) tb_v <= ta_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tb_ax <= ta_ax;
      tb_xcp <= ta_xcp;
      tb_hy <= hy_sat;
      tb_my <= (2*TW+16)'(ta_ax.y) * (2*TW+16)'(ta_srsp);
      tb_mz <= (2*TW+16)'(ta_ax.z) * (2*TW+16)'(ta_crsp);
    end
  end

  // tilt stage c: horizontal x
  localparam int HW = 2*TW + 20;
  logic tc_v;
  chc_pkg::axes_t tc_ax;
  logic signed [17:0] tc_hx, tc_hy;
  logic signed [HW-1:0] hx_sum, hx_sh;
  logic signed [17:0] hx_sat;

  assign hx_sum = (HW'(tb_xcp) <<< 16) + HW'(tb_my) - HW'(tb_mz) + (HW'(1) <<< 31);
  assign hx_sh = hx_sum >>> 32;

  always_comb begin
    if (hx_sh > HW'(131071)) hx_sat = 18'sh1ffff;
    else if (hx_sh < -HW'(131072)) hx_sat = 18'sh20000;
    else hx_sat = 18'(hx_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) tc_v <= 1'b0;
    else if (adv) tc_v <= tb_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tc_ax <= tb_ax;
      tc_hx <= hx_sat;
      tc_hy <= tb_hy;
    end
  end

  // arctangent setup: axis cases and half-plane fold
  logic signed [VW-1:0] vx [0:NSTEPS];
  logic signed [VW-1:0] vy [0:NSTEPS];
  logic signed [AW-1:0] vz [0:NSTEPS];
  logic vv [0:NSTEPS];
  chc_pkg::post_t vm [0:NSTEPS];
  logic signed [VW-1:0] ix, iy;
  chc_pkg::post_t im;

  assign ix = VW'(tc_hx) <<< 14;
  assign iy = VW'(tc_hy) <<< 14;

  always_comb begin
    im.ax = tc_ax;
    im.hx = tc_hx;
    im.hy = tc_hy;
    im.spec = 1'b0;
    im.spec_val = '0;
    if (tc_hy == 18'sd0) begin
      im.spec = 1'b1;
      im.spec_val = (tc_hx < 0) ? 16'sd18000 : 16'sd0;
    end else if (tc_hx == 18'sd0) begin
      im.spec = 1'b1;
      im.spec_val = (tc_hy > 0) ? 16'sd9000 : -16'sd9000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vv[0] <= 1'b0;
    else if (adv) vv[0] <= tc_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vm[0] <= im;
      if (tc_hx < 0) begin
        vx[0] <= -ix;
        vy[0] <= -iy;
        vz[0] <= (tc_hy >= 0) ? chc_pkg::HALF_TURN : -chc_pkg::HALF_TURN;
      end else begin
        vx[0] <= ix;
        vy[0] <= iy;
        vz[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < NSTEPS; k++) begin : g_vec
    chc_vec_stage #(.SHIFT(k)) u_vec (
      .clk(clk), .en(adv),
      .x_in(vx[k]), .y_in(vy[k]), .z_in(vz[k]),
      .x_out(vx[k+1]), .y_out(vy[k+1]), .z_out(vz[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) vv[k+1] <= 1'b0;
      else if (adv) vv[k+1] <= vv[k];
    end
    always_ff @(posedge clk) begin
      if (adv) vm[k+1] <= vm[k];
    end
  end

  // output: round, add declination, wrap
  chc_pkg::post_t fm;
  logic signed [AW-1:0] zr;
  logic signed [17:0] h0, h1, h2, h3, h4;

  assign fm = vm[NSTEPS];
  assign zr = (vz[NSTEPS] + AW'(128)) >>> 8;

  always_comb begin
    h0 = fm.spec ? 18'(fm.spec_val) : 18'(zr);
    h1 = h0 + 18'(declination);
    h2 = (h1 > 18'sd18000) ? h1 - 18'sd36000 : h1;
    h3 = (h2 > 18'sd18000) ? h2 - 18'sd36000 : h2;
    h4 = (h3 <= -18'sd18000) ? h3 + 18'sd36000 : h3;
    if (h4 <= -18'sd18000) h4 = h4 + 18'sd36000;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vv[NSTEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading <= 16'(h4);
      corrected_x <= fm.ax.x;
      corrected_y <= fm.ax.y;
      corrected_z <= fm.ax.z;
      horizontal_x <= fm.hx;
      horizontal_y <= fm.hy;
    end
  end

endmodule
`default_nettype wire

@@ rtl/chc_checker.sv @@
// port level checks for the compass heading pipeline, bound to the top level
`default_nettype none
module chc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic signed [15:0] heading
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  a_stall_follow: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading > -16'sd18000 && heading <= 16'sd18000))
    else $error("heading out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(heading))
    else $error("stalled result word changed");

endmodule

bind compass_heading_calc_top chc_checker u_chc_checker (.*);
`default_nettype wire
